[hdl/ccar_pkg.sv]
// Package for the CRC-32 checked chunk acknowledge receiver.
// Holds the action, operation, result and register codes, the queue entry types
// and the byte-wise CRC-32 function. It depends on nothing.
package ccar_pkg;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BAD   = 2'd1;
    localparam logic [1:0] OP_BYTE  = 2'd2;
    localparam logic [1:0] OP_TICK  = 2'd3;

    localparam logic [2:0] KIND_ACK      = 3'd0;
    localparam logic [2:0] KIND_DONE     = 3'd1;
    localparam logic [2:0] KIND_MISMATCH = 3'd2;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd3;
    localparam logic [2:0] KIND_BAD_SIZE = 3'd4;

    localparam logic [7:0] CFG_CHUNK_BYTES = 8'd0;
    localparam logic [7:0] CFG_IDLE_LIMIT  = 8'd1;
    localparam logic [7:0] CFG_MAX_SIZE    = 8'd2;

    localparam logic [16:0] CHUNK_BYTES_RST = 17'd4096;
    localparam logic [15:0] IDLE_LIMIT_RST  = 16'd50;
    localparam logic [31:0] MAX_SIZE_RST    = 32'd16777216;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data_byte;
        logic [31:0] transfer_size;
        logic        check_crc;
    } t_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] byte_count;
        logic [31:0] computed_crc;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_rsp_pair;

    function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
        logic [31:0] v;
        v = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            v = (v >> 1) ^ (CRC_POLY & {32{v[0]}});
        end
        return v;
    endfunction

endpackage

[hdl/ccar_front.sv]
// Front end of the receiver: takes requests, classifies them and queues them.
// Uses ccar_pkg for the action and operation codes and the queue entry type.
module ccar_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic [7:0]            i_data_byte,
    input  logic [31:0]           i_transfer_size,
    input  logic                  i_check_crc,
    input  logic [31:0]           i_max_size,
    output logic                  o_item_valid,
    output ccar_pkg::t_item       o_item,
    input  logic                  i_pop
);
    import ccar_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_wp;
    logic       n_rp;
    logic [1:0] n_cnt;
    t_item      w_item;
    logic       w_keep;
    logic       w_push;

    assign o_in_ready = (r_cnt != 2'd2);

    always_comb begin
        w_item.data_byte     = i_data_byte;
        w_item.transfer_size = i_transfer_size;
        w_item.check_crc     = i_check_crc;
        w_keep               = 1'b1;
        case (i_action)
            ACT_START: begin
                if ((i_transfer_size == 32'd0) || (i_transfer_size > i_max_size)) begin
                    w_item.op = OP_BAD;
                end else begin
                    w_item.op = OP_START;
                end
            end
            ACT_BYTE: w_item.op = OP_BYTE;
            ACT_TICK: w_item.op = OP_TICK;
            default: begin
                w_item.op = OP_TICK;
                w_keep    = 1'b0;
            end
        endcase
    end

    assign w_push = i_in_valid && o_in_ready && w_keep;

    always_comb begin
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ i_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_item;
        end
    end

    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_mem[r_rp];

endmodule

[hdl/ccar_back.sv]
// Back end of the receiver: transfer state, CRC-32 update, chunk and trailer handling.
// Uses ccar_pkg for the codes, the queue entry types and the CRC function.
module ccar_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    input  ccar_pkg::t_item       i_item,
    input  logic                  i_room,
    output logic                  o_pop,
    output ccar_pkg::t_rsp_pair   o_rsp,
    input  logic [16:0]           i_chunk_bytes,
    input  logic [15:0]           i_idle_limit
);
    import ccar_pkg::*;

    localparam logic [1:0] PH_IDLE    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;

    logic [1:0]  r_phase, n_phase;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_target, n_target;
    logic [31:0] r_count, n_count;
    logic [16:0] r_fill, n_fill;
    logic [15:0] r_idle, n_idle;
    logic        r_want, n_want;
    logic [31:0] r_tword, n_tword;
    logic [2:0]  r_tidx, n_tidx;

    assign o_pop = i_item_valid && i_room;

    always_comb begin
        logic [15:0] idle_inc;
        n_phase  = r_phase;
        n_crc    = r_crc;
        n_target = r_target;
        n_count  = r_count;
        n_fill   = r_fill;
        n_idle   = r_idle;
        n_want   = r_want;
        n_tword  = r_tword;
        n_tidx   = r_tidx;
        idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
        o_rsp.cnt = 2'd0;
        o_rsp.r0  = '0;
        o_rsp.r1  = '0;
        if (o_pop) begin
            case (i_item.op)
                OP_START, OP_BAD: begin
                    n_crc   = CRC_INIT;
                    n_count = 32'd0;
                    n_fill  = 17'd0;
                    n_idle  = 16'd0;
                    n_tword = 32'd0;
                    n_tidx  = 3'd0;
                    if (i_item.op == OP_BAD) begin
                        n_phase   = PH_IDLE;
                        n_target  = 32'd0;
                        n_want    = 1'b0;
                        o_rsp.cnt = 2'd1;
                        o_rsp.r0  = '{KIND_BAD_SIZE, 32'd0, 32'd0, 1'b1};
                    end else begin
                        n_phase  = PH_PAYLOAD;
                        n_target = i_item.transfer_size;
                        n_want   = i_item.check_crc;
                    end
                end
                OP_BYTE: begin
                    if (r_phase == PH_PAYLOAD) begin
                        n_idle  = 16'd0;
                        n_crc   = crc_byte(r_crc, i_item.data_byte);
                        n_count = r_count + 32'd1;
                        n_fill  = r_fill + 17'd1;
                        if (n_count >= r_target) begin
                            n_fill = 17'd0;
                            if (r_want) begin
                                n_phase   = PH_TRAILER;
                                n_tword   = 32'd0;
                                n_tidx    = 3'd0;
                                o_rsp.cnt = 2'd1;
                                o_rsp.r0  = '{KIND_ACK, n_count, ~n_crc, 1'b1};
                            end else begin
                                n_phase   = PH_IDLE;
                                o_rsp.cnt = 2'd2;
                                o_rsp.r0  = '{KIND_ACK, n_count, ~n_crc, 1'b0};
                                o_rsp.r1  = '{KIND_DONE, n_count, ~n_crc, 1'b1};
                            end
                        end else if (n_fill >= i_chunk_bytes) begin
                            n_fill    = 17'd0;
                            o_rsp.cnt = 2'd1;
                            o_rsp.r0  = '{KIND_ACK, n_count, ~n_crc, 1'b1};
                        end
                    end else if (r_phase == PH_TRAILER) begin
                        n_idle  = 16'd0;
                        n_tword = r_tword
                                | ({24'd0, i_item.data_byte} << {r_tidx[1:0], 3'b000});
                        n_tidx  = r_tidx + 3'd1;
                        if (n_tidx[2]) begin
                            n_phase   = PH_IDLE;
                            n_tidx    = 3'd0;
                            o_rsp.cnt = 2'd1;
                            o_rsp.r0  = '{(n_tword == ~r_crc) ? KIND_DONE : KIND_MISMATCH,
                                          r_count, ~r_crc, 1'b1};
                        end
                    end
                end
                OP_TICK: begin
                    if (r_phase == PH_PAYLOAD || r_phase == PH_TRAILER) begin
                        if (idle_inc >= i_idle_limit) begin
                            n_phase   = PH_IDLE;
                            n_idle    = 16'd0;
                            o_rsp.cnt = 2'd1;
                            o_rsp.r0  = '{KIND_TIMEOUT, r_count, ~r_crc, 1'b1};
                        end else begin
                            n_idle = idle_inc;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_crc    <= CRC_INIT;
            r_target <= 32'd0;
            r_count  <= 32'd0;
            r_fill   <= 17'd0;
            r_idle   <= 16'd0;
            r_want   <= 1'b0;
            r_tword  <= 32'd0;
            r_tidx   <= 3'd0;
        end else begin
            r_phase  <= n_phase;
            r_crc    <= n_crc;
            r_target <= n_target;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_idle   <= n_idle;
            r_want   <= n_want;
            r_tword  <= n_tword;
            r_tidx   <= n_tidx;
        end
    end

endmodule

[hdl/ccar_outq.sv]
// Result queue of the receiver: takes up to two results a cycle, hands out one.
// Uses ccar_pkg for the result types.
module ccar_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ccar_pkg::t_rsp_pair   i_rsp,
    output logic                  o_room,
    output logic [2:0]            o_level,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ccar_pkg::t_result     o_result
);
    import ccar_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_cnt, n_cnt;
    logic       w_pop;

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_result    = r_mem[r_rp];
    assign o_room      = (r_cnt <= 3'd2);
    assign o_level     = r_cnt;
    assign w_pop       = o_out_valid && i_out_ready;

    always_comb begin
        n_wp  = r_wp + i_rsp.cnt;
        n_rp  = r_rp + {1'b0, w_pop};
        n_cnt = r_cnt + {1'b0, i_rsp.cnt} - {2'd0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rsp.cnt != 2'd0) begin
            r_mem[r_wp] <= i_rsp.r0;
        end
        if (i_rsp.cnt == 2'd2) begin
            r_mem[r_wp + 2'd1] <= i_rsp.r1;
        end
    end

endmodule

[hdl/crc32_checked_chunk_ack_receiver.sv]
// Receiver for a length-prefixed payload, acknowledged in chunks, with a CRC-32 trailer.
// Top level: configuration registers, front end, back end and result queue.
// Depends on ccar_pkg, ccar_front, ccar_back and ccar_outq.
//
// Usage. A request on the input channel is a start (size and CRC check flag), a
// received byte or an idle tick. The back end produces acknowledgements with the
// cumulative byte count, a done or CRC mismatch verdict, a timeout, or a bad size
// report; each leaves on the result channel with last set on the final result of
// its request. The configuration channel is always ready and should only be
// written while no request is in flight.
// A request is registered in the input queue and its results in the result queue;
// a second result of the same request is written together with the first.
// Throughput is one request per cycle while two result slots are free, set by the
// combinational byte-wise CRC update and state update in the back end.
// A two-entry input queue and a four-entry result queue separate the sides: when
// the receiver stalls, the back end stops once fewer than two result slots are
// free and the input channel stalls when the input queue is full.
// Reset is synchronous and active low; it empties both queues, returns the
// transfer state to idle and loads the register defaults.
module crc32_checked_chunk_ack_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_transfer_size,
    input  logic        i_check_crc,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_kind,
    output logic [31:0] o_byte_count,
    output logic [31:0] o_computed_crc,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ccar_pkg::*;

    logic [16:0] r_chunk_bytes;
    logic [15:0] r_idle_limit;
    logic [31:0] r_max_size;
    logic        w_item_valid;
    t_item       w_item;
    logic        w_pop;
    logic        w_room;
    logic [2:0]  w_level;
    t_rsp_pair   w_rsp;
    t_result     w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_bytes <= CHUNK_BYTES_RST;
            r_idle_limit  <= IDLE_LIMIT_RST;
            r_max_size    <= MAX_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CHUNK_BYTES: r_chunk_bytes <= i_cfg_data[16:0];
                CFG_IDLE_LIMIT:  r_idle_limit  <= i_cfg_data[15:0];
                CFG_MAX_SIZE:    r_max_size    <= i_cfg_data;
                default: begin
                    r_max_size <= r_max_size;
                end
            endcase
        end
    end

    ccar_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_transfer_size (i_transfer_size),
        .i_check_crc     (i_check_crc),
        .i_max_size      (r_max_size),
        .o_item_valid    (w_item_valid),
        .o_item          (w_item),
        .i_pop           (w_pop)
    );

    ccar_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (w_item_valid),
        .i_item        (w_item),
        .i_room        (w_room),
        .o_pop         (w_pop),
        .o_rsp         (w_rsp),
        .i_chunk_bytes (r_chunk_bytes),
        .i_idle_limit  (r_idle_limit)
    );

    ccar_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rsp       (w_rsp),
        .o_room      (w_room),
        .o_level     (w_level),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (w_result)
    );

    assign o_kind         = w_result.kind;
    assign o_byte_count   = w_result.byte_count;
    assign o_computed_crc = w_result.computed_crc;
    assign o_last         = w_result.last;

`ifndef SYNTHESIS
    a_push_needs_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rsp.cnt != 2'd0) |-> w_pop)
        else $error("Results produced without a request taken from the input queue.");

    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_item_valid && (w_level <= 3'd2)))
        else $error("Request taken without a queued request or two free result slots.");

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= 3'd4)
        else $error("Result queue level exceeds its depth.");
`endif

endmodule

[dv/tb.sv]
// Self-checking testbench for the CRC-32 checked chunk acknowledge receiver.
// It predicts acknowledgements, verdicts, timeouts and size rejections per request
// and compares every result; it depends only on ccar_pkg and the top-level RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccar_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;
    localparam logic [7:0]  CFG_UNMAPPED  = 8'hFF;

    typedef enum logic [1:0] {PH_IDLE, PH_PAYLOAD, PH_TRAILER} t_rx_phase;

    class t_ack_predictor;
        logic [16:0] chunk_bytes;
        logic [15:0] idle_limit;
        logic [31:0] max_size;
        t_rx_phase   phase;
        logic [31:0] crc_reg;
        logic [31:0] target;
        logic [31:0] count;
        logic [16:0] fill;
        logic [15:0] idle_ticks;
        logic        want_check;
        logic [31:0] trailer;
        logic [2:0]  trailer_pos;
        t_result     pending_results[$];
        int unsigned failures;
        int unsigned effective;

        function new();
            chunk_bytes = CHUNK_BYTES_RST;
            idle_limit  = IDLE_LIMIT_RST;
            max_size    = MAX_SIZE_RST;
            phase       = PH_IDLE;
            crc_reg     = CRC_INIT;
            target      = '0;
            count       = '0;
            fill        = '0;
            idle_ticks  = '0;
            want_check  = 1'b0;
            trailer     = '0;
            trailer_pos = '0;
            failures    = 0;
            effective   = 0;
        endfunction

        static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
            logic [31:0] r;
            r = c;
            for (int i = 0; i < 8; i++) begin
                if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
                else r = r >> 1;
            end
            return r;
        endfunction

        function void write_register(logic [7:0] idx, logic [31:0] val);
            case (idx)
                CFG_CHUNK_BYTES: chunk_bytes = val[16:0];
                CFG_IDLE_LIMIT:  idle_limit  = val[15:0];
                CFG_MAX_SIZE:    max_size    = val;
                default: ;
            endcase
        endfunction

        function void queue_result(logic [2:0] kind, logic [31:0] cnt, logic [31:0] crc,
                                   logic last);
            t_result r;
            r.kind         = kind;
            r.byte_count   = cnt;
            r.computed_crc = crc;
            r.last         = last;
            pending_results.push_back(r);
        endfunction

        function void note_request(logic [1:0] act, logic [7:0] data, logic [31:0] size,
                                   logic chk);
            if (act == ACT_START) begin
                effective++;
                crc_reg     = CRC_INIT;
                count       = '0;
                fill        = '0;
                idle_ticks  = '0;
                trailer     = '0;
                trailer_pos = '0;
                if (size == 32'd0 || size > max_size) begin
                    phase      = PH_IDLE;
                    target     = '0;
                    want_check = 1'b0;
                    queue_result(KIND_BAD_SIZE, '0, '0, 1'b1);
                end else begin
                    phase      = PH_PAYLOAD;
                    target     = size;
                    want_check = chk;
                end
            end else if (act == ACT_BYTE && phase == PH_PAYLOAD) begin
                effective++;
                idle_ticks = '0;
                crc_reg    = crc_next(crc_reg, data);
                count++;
                fill++;
                if (count >= target) begin
                    fill = '0;
                    queue_result(KIND_ACK, count, ~crc_reg, want_check);
                    if (want_check) begin
                        phase       = PH_TRAILER;
                        trailer     = '0;
                        trailer_pos = '0;
                    end else begin
                        phase = PH_IDLE;
                        queue_result(KIND_DONE, count, ~crc_reg, 1'b1);
                    end
                end else if (fill >= chunk_bytes) begin
                    fill = '0;
                    queue_result(KIND_ACK, count, ~crc_reg, 1'b1);
                end
            end else if (act == ACT_BYTE && phase == PH_TRAILER) begin
                effective++;
                idle_ticks = '0;
                trailer    = trailer | ({24'd0, data} << (8 * trailer_pos[1:0]));
                trailer_pos++;
                if (trailer_pos >= 3'd4) begin
                    phase       = PH_IDLE;
                    trailer_pos = '0;
                    queue_result((trailer == ~crc_reg) ? KIND_DONE : KIND_MISMATCH,
                                 count, ~crc_reg, 1'b1);
                end
            end else if (act == ACT_TICK && phase != PH_IDLE) begin
                effective++;
                if (idle_ticks != 16'hFFFF) idle_ticks++;
                if (idle_ticks >= idle_limit) begin
                    phase      = PH_IDLE;
                    idle_ticks = '0;
                    queue_result(KIND_TIMEOUT, count, ~crc_reg, 1'b1);
                end
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result with none expected: kind %0d byte_count %0d",
                       got.kind, got.byte_count);
                failures++;
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                failures++;
            end
            if (got.byte_count !== want.byte_count) begin
                $error("byte_count: expected %0d, actual %0d", want.byte_count, got.byte_count);
                failures++;
            end
            if (got.computed_crc !== want.computed_crc) begin
                $error("computed_crc: expected %h, actual %h", want.computed_crc,
                       got.computed_crc);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [7:0]  i_data_byte;
    logic [31:0] i_transfer_size;
    logic        i_check_crc;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_kind;
    logic [31:0] o_byte_count;
    logic [31:0] o_computed_crc;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    t_ack_predictor rx_pred;
    int unsigned    hold_off_request = 0;
    bit             gaps_on = 1'b1;
    int unsigned    cycle_count = 0;

    crc32_checked_chunk_ack_receiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (i_action),
        .i_data_byte     (i_data_byte),
        .i_transfer_size (i_transfer_size),
        .i_check_crc     (i_check_crc),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_kind          (o_kind),
        .o_byte_count    (o_byte_count),
        .o_computed_crc  (o_computed_crc),
        .o_last          (o_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_request(input logic [1:0] act, input logic [7:0] data,
                                input logic [31:0] size, input logic chk);
        while (gaps_on && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= act;
        i_data_byte     <= data;
        i_transfer_size <= size;
        i_check_crc     <= chk;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rx_pred.note_request(act, data, size, chk);
    endtask

    task automatic send_filler(input logic [1:0] act);
        send_request(act, 8'($urandom()), 32'($urandom()), 1'($urandom()));
    endtask

    task automatic send_trailer(input logic [31:0] word, input bit corrupt,
                                input int unsigned tick_pct);
        logic [31:0] w;
        int unsigned pos;
        w   = word;
        pos = $urandom_range(0, 31);
        if (corrupt) w[pos] = ~w[pos];
        for (int n = 0; n < 4; n++) begin
            if ($urandom_range(0, 99) < tick_pct) send_filler(ACT_TICK);
            send_request(ACT_BYTE, w[8 * n +: 8], 32'($urandom()), 1'($urandom()));
        end
    endtask

    task automatic run_transfer(input int unsigned size_cap, input int unsigned tick_pct);
        logic [31:0] size;
        logic        chk;
        size = $urandom_range(1, size_cap);
        chk  = 1'($urandom());
        send_request(ACT_START, 8'($urandom()), size, chk);
        for (int unsigned n = 0; n < size; n++) begin
            if ($urandom_range(0, 99) < tick_pct) send_filler(ACT_TICK);
            if ($urandom_range(0, 199) == 0) return;
            send_filler(ACT_BYTE);
        end
        if (chk) send_trailer(~rx_pred.crc_reg, $urandom_range(0, 3) == 0, tick_pct);
    endtask

    task automatic send_noise();
        logic [31:0] size;
        case ($urandom_range(0, 3))
            0: send_filler(ACT_BYTE);
            1: send_filler(ACT_TICK);
            2: send_filler(ACT_UNUSED);
            default: begin
                case ($urandom_range(0, 2))
                    0:       size = '0;
                    1:       size = rx_pred.max_size + 32'd1;
                    default: size = $urandom();
                endcase
                send_request(ACT_START, 8'($urandom()), size, 1'($urandom()));
            end
        endcase
    endtask

    task automatic run_phase(input int unsigned quota, input int unsigned size_cap,
                             input int unsigned tick_pct);
        int unsigned goal;
        goal = rx_pred.effective + quota;
        while (rx_pred.effective < goal) begin
            if ($urandom_range(0, 99) < 15) send_noise();
            else run_transfer(size_cap, tick_pct);
        end
    endtask

    // Registers change only once the block has drained, including requests that
    // produce no result and may still sit in the input queue.
    task automatic load_settings(input logic [31:0] chunk, input logic [31:0] idle_lim,
                                 input logic [31:0] size_max);
        logic [7:0]  idx [4];
        logic [31:0] val [4];
        idx = '{CFG_CHUNK_BYTES, CFG_IDLE_LIMIT, CFG_MAX_SIZE, CFG_UNMAPPED};
        val = '{chunk, idle_lim, size_max, 32'($urandom())};
        i_in_valid <= 1'b0;
        while (rx_pred.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            rx_pred.write_register(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        t_result     seen;
        int unsigned stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                seen.kind         = o_kind;
                seen.byte_count   = o_byte_count;
                seen.computed_crc = o_computed_crc;
                seen.last         = o_last;
                rx_pred.check_result(seen);
            end
            if (hold_off_request != 0) begin
                stall_left       = hold_off_request;
                hold_off_request = 0;
            end
            if (stall_left != 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
            end
        end
    end

    initial begin
        rx_pred = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_START;
        i_data_byte     <= '0;
        i_transfer_size <= '0;
        i_check_crc     <= 1'b0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_CHUNK_BYTES;
        i_cfg_data      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Requests while idle are ignored; then both kinds of bad size, a plain transfer and a checked one.
        send_filler(ACT_BYTE);
        send_filler(ACT_TICK);
        send_filler(ACT_UNUSED);
        send_request(ACT_START, 8'h00, 32'd0, 1'b1);
        send_request(ACT_START, 8'hFF, 32'hFFFF_FFFF, 1'b0);
        send_request(ACT_START, 8'h5A, 32'd2, 1'b0);
        send_request(ACT_BYTE, 8'h00, 32'd0, 1'b0);
        send_request(ACT_BYTE, 8'hFF, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_START, 8'h00, 32'd1, 1'b1);
        send_request(ACT_BYTE, 8'hA5, 32'd0, 1'b0);
        send_trailer(~rx_pred.crc_reg, 1'b0, 0);
        // A restart drops the open transfer; the new one ends with a bad trailer.
        send_request(ACT_START, 8'h00, 32'd5, 1'b0);
        send_request(ACT_BYTE, 8'h3C, 32'd0, 1'b0);
        send_request(ACT_START, 8'h00, 32'd1, 1'b1);
        send_request(ACT_BYTE, 8'hC3, 32'd0, 1'b0);
        send_trailer(~rx_pred.crc_reg, 1'b1, 0);

        // Every byte closes a chunk; a byte clears the idle count before the timeout.
        load_settings(32'd0, 32'd2, 32'hFFFF_FFFF);
        send_request(ACT_START, 8'h00, 32'hFFFF_FFFF, 1'b1);
        send_request(ACT_BYTE, 8'h81, 32'd0, 1'b0);
        send_request(ACT_TICK, 8'h00, 32'd0, 1'b0);
        send_request(ACT_BYTE, 8'h7E, 32'd0, 1'b0);
        send_request(ACT_TICK, 8'h00, 32'd0, 1'b0);
        send_request(ACT_TICK, 8'h00, 32'd0, 1'b0);

        load_settings(32'd1, 32'd3, 32'd64);
        hold_off_request = 300;
        run_phase(250, 70, 6);

        load_settings(32'd0, 32'd1, 32'd20);
        run_phase(200, 24, 1);

        load_settings(32'd7, 32'd5, 32'hFFFF_FFFF);
        gaps_on = 1'b0;
        run_phase(250, 40, 6);
        gaps_on = 1'b1;

        load_settings(32'd65536, 32'd65535, 32'd100);
        run_phase(200, 110, 6);

        load_settings(32'd16, 32'd0, 32'd1);
        run_phase(150, 2, 1);

        load_settings(32'd3, 32'd4, 32'd32);
        hold_off_request = 400;
        run_phase(300, 36, 8);

        i_in_valid <= 1'b0;
        while (rx_pred.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (rx_pred.failures == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/ccar_pkg.sv
hdl/ccar_front.sv
hdl/ccar_back.sv
hdl/ccar_outq.sv
hdl/crc32_checked_chunk_ack_receiver.sv
dv/tb.sv
